### rtl/core/upe_pkg.sv
package upe_pkg;

   // Work queue between classifier and emitter
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAddrW = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   // Emitter step numbers: "%hh%hh" occupies steps 0..5
   localparam logic [2:0] StepPrefixPct = 3'd0;
   localparam logic [2:0] StepByteEsc   = 3'd3;
   localparam logic [2:0] StepLast      = 3'd5;

   localparam logic [7:0] CharPct   = 8'h25;
   localparam logic [7:0] LeadC2    = 8'hC2;
   localparam logic [7:0] Latin1Adj = 8'h40;

   // One classified input byte
   typedef struct packed {
      logic       pass;       // emit value as is, single char
      logic [2:0] first_step; // StepPrefixPct for two-escape bytes, StepByteEsc otherwise
      logic       lead_c3;    // UTF-8 lead byte is c3 rather than c2
      logic [7:0] value;      // byte to show (pass) or to escape last
   } desc_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] n8;
      n8 = {4'd0, nib};
      hex_char = (nib < 4'd10) ? (8'h30 + n8) : (8'h57 + n8);
   endfunction

endpackage

### rtl/core/url_percent_encoder.sv
// A byte's first character passes the queue, the emitter's entry register and the output
// register to rsp_*. Throughput: one character per cycle while the emitter has an entry;
// a byte gives 1 character (pass-through or zero), 3 (ASCII escape) or 6 (Latin-1).
// A 4-deep queue absorbs bursts; busy rises when it fills. The receiver cannot stall.
// Reset (synchronous, active high) empties the queue and idles the emitter.
module url_percent_encoder
   import upe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_in_byte,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   // front -> queue
   logic     push;
   desc_type push_desc;
   // queue -> back
   logic     pop;
   desc_type pop_desc;
   logic     q_full;
   logic     q_empty;

   // Classifier: decides pass-through / 3-char / 6-char form for each beat
   upe_front u_front (
      .start       (start),
      .q_full      (q_full),
      .req_in_byte (req_in_byte),
      .busy        (busy),
      .push        (push),
      .push_desc   (push_desc)
   );

   // Decouples intake from the emitter
   upe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Emitter: steps through the characters, loading the next entry on the
   // cycle it sends the last character, so runs go out gap-free
   upe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_desc          (pop_desc),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

### rtl/core/upe_front.sv
module upe_front
   import upe_pkg::*;
(
   input  logic       start,
   input  logic       q_full,
   input  logic [7:0] req_in_byte,
   output logic       busy,
   output logic       push,
   output desc_type   push_desc
);

   logic b_alpha;
   logic b_digit;
   logic b_mark;
   logic b_ascii;
   logic b_low_latin;

   always_comb begin
      b_alpha = ((req_in_byte >= 8'h41) && (req_in_byte <= 8'h5A)) ||
                ((req_in_byte >= 8'h61) && (req_in_byte <= 8'h7A));
      b_digit = (req_in_byte >= 8'h30) && (req_in_byte <= 8'h39);
      b_mark  = (req_in_byte == 8'h2D) || (req_in_byte == 8'h2E) ||
                (req_in_byte == 8'h5F) || (req_in_byte == 8'h21) ||
                (req_in_byte == 8'h28) || (req_in_byte == 8'h29) ||
                (req_in_byte == 8'h2A);
      b_ascii     = ~req_in_byte[7];
      b_low_latin = req_in_byte[7] & ~req_in_byte[6];

      push_desc.pass       = (req_in_byte == 8'h00) | b_alpha | b_digit | b_mark;
      push_desc.first_step = b_ascii ? StepByteEsc : StepPrefixPct;
      push_desc.lead_c3    = req_in_byte[7] & req_in_byte[6];
      // 0xC0-0xFF shows as continuation byte (byte - 0x40)
      push_desc.value      = (b_ascii | b_low_latin) ? req_in_byte
                                                     : (req_in_byte - Latin1Adj);
   end

   assign busy = q_full;
   assign push = start & ~q_full;

endmodule

### rtl/core/upe_queue.sv
module upe_queue
   import upe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output desc_type pop_desc,
   output logic     full,
   output logic     empty
);

   desc_type                mem [QueueDepth];
   logic [QueueAddrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueueAddrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]    count_ff, count_in;

   assign full     = (count_ff == QueueCntW'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign pop_desc = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueueAddrW'(push);
      rd_ptr_in = rd_ptr_ff + QueueAddrW'(pop);
      count_in  = count_ff + QueueCntW'(push) - QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/upe_back.sv
module upe_back
   import upe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  desc_type   q_desc,
   output logic       pop,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   logic       cur_valid_ff, cur_valid_in;
   desc_type   cur_ff, cur_in;
   logic [2:0] step_ff, step_in;
   logic       strobe_ff, strobe_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       at_last;
   logic [7:0] esc_byte;

   assign at_last = cur_ff.pass | (step_ff == StepLast);
   assign pop     = ~q_empty & (~cur_valid_ff | at_last);

   always_comb begin
      // steps 0..2 escape the lead byte, 3..5 the value
      esc_byte = (step_ff < StepByteEsc) ? (LeadC2 | {7'd0, cur_ff.lead_c3}) : cur_ff.value;
      unique case (step_ff)
         3'd0, 3'd3: char_in = CharPct;
         3'd1, 3'd4: char_in = hex_char(esc_byte[7:4]);
         default:    char_in = hex_char(esc_byte[3:0]);
      endcase
      if (cur_ff.pass) begin
         char_in = cur_ff.value;
      end
      strobe_in = cur_valid_ff;
      last_in   = at_last;

      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      step_in      = step_ff + 3'd1;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_in       = q_desc;
         step_in      = q_desc.first_step;
      end else if (cur_valid_ff & at_last) begin
         cur_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      step_ff <= step_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         strobe_ff    <= strobe_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_last_of_run = last_ff;

endmodule

### bench/testbench.sv
module testbench;
   import upe_pkg::*;

   // Cycles with neither an accepted input nor a result before the run is declared hung.
   // Worst legal quiet stretch: the longest sender gap plus pipeline latency. While the
   // 4-deep queue drains (up to 24 chars), results keep coming, so the limit is ample.
   localparam int unsigned HangLimit    = 300;
   localparam int unsigned RandomBeats  = 125;
   localparam int unsigned SteadyBeats  = 30;   // final random beats sent back to back
   localparam int unsigned DrainCycles  = 10;   // first char passes the queue and emitter registers after accept

   // One expected output character
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } enc_char_type;

   // Directed row: a byte and, where obvious, its encoding typed in (top chars first).
   // n_typed == 0 means the row is checked against the predictor.
   typedef struct packed {
      logic [7:0]  in_byte;
      logic [2:0]  n_typed;
      logic [47:0] typed;
   } dir_row_type;

   localparam int unsigned NumDirected = 25;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [7:0] req_in_byte;
   logic       rsp_strobe;
   logic [7:0] rsp_out_char;
   logic       rsp_last_of_run;

   enc_char_type pending_chars[$];
   int unsigned  mismatches;
   int unsigned  quiet_cycles;

   dir_row_type directed_rows [NumDirected];

   url_percent_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_in_byte     (req_in_byte),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------- encoding predictor

   // Unreserved set: letters, digits and - . _ ! ( ) *
   function automatic bit is_unreserved(input logic [7:0] b);
      if (b >= "A" && b <= "Z") return 1'b1;
      if (b >= "a" && b <= "z") return 1'b1;
      if (b >= "0" && b <= "9") return 1'b1;
      case (b)
         "-", ".", "_", "!", "(", ")", "*": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] lc_hex_digit(input logic [3:0] nib);
      string digits;
      digits = "0123456789abcdef";
      return digits[nib];
   endfunction

   // Queue '%' plus two lowercase hex digits; the last flag goes on the low digit
   function automatic void queue_escape(input logic [7:0] v, input bit ends_run);
      pending_chars.push_back('{ch: 8'h25, last: 1'b0});
      pending_chars.push_back('{ch: lc_hex_digit(v[7:4]), last: 1'b0});
      pending_chars.push_back('{ch: lc_hex_digit(v[3:0]), last: ends_run});
   endfunction

   // Queue every character that one input byte should produce
   function automatic void predict_encoding(input logic [7:0] b);
      if (b == 8'h00 || is_unreserved(b)) begin
         pending_chars.push_back('{ch: b, last: 1'b1});
      end else if (b < 8'h80) begin
         queue_escape(b, 1'b1);
      end else if (b < 8'hC0) begin
         // Latin-1 0x80-0xBF, lead byte c2
         queue_escape(8'hC2, 1'b0);
         queue_escape(b, 1'b1);
      end else begin
         // lead byte c3, continuation is byte - 0x40
         queue_escape(8'hC3, 1'b0);
         queue_escape(b - 8'h40, 1'b1);
      end
   endfunction

   // ---------------------------------------------------------------- input side

   // Present one beat and hold it until an edge sees busy low. busy is read right after
   // the edge, before any update from it, so it is the value the block sampled.
   task automatic drive_beat(input logic [7:0] b);
      start       <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (busy);
   endtask

   // Sender gap: a random burst of idle cycles, about one beat in three
   task automatic maybe_idle();
      if ($urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Random byte biased toward each encoding class
   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: b = 8'($urandom_range(0, 255));
         4, 5: begin
            do b = 8'($urandom_range(8'h21, 8'h7A)); while (!is_unreserved(b));
         end
         6:       b = 8'h00;                               // string terminator
         7, 8:    b = 8'($urandom_range(8'h80, 8'hFF));    // two-escape bytes
         default: b = 8'($urandom_range(8'h01, 8'h7F));    // ASCII
      endcase
      return b;
   endfunction

   initial begin
      // Boundaries of every character range, each unreserved punctuation mark, and the
      // corners of both Latin-1 halves. Obvious encodings are typed in.
      directed_rows = '{
         '{8'h00, 3'd1, 48'h0},                 // terminator: a single zero char
         '{8'h41, 3'd0, 48'h0},
         '{8'h5A, 3'd0, 48'h0},
         '{8'h61, 3'd0, 48'h0},
         '{8'h7A, 3'd0, 48'h0},
         '{8'h30, 3'd0, 48'h0},
         '{8'h39, 3'd0, 48'h0},
         '{8'h40, 3'd0, 48'h0},                 // '@' just below 'A'
         '{8'h7B, 3'd0, 48'h0},                 // '{' just above 'z'
         '{8'h2D, 3'd0, 48'h0},
         '{8'h2E, 3'd0, 48'h0},
         '{8'h5F, 3'd1, {"_", 40'd0}},
         '{8'h21, 3'd1, {"!", 40'd0}},
         '{8'h28, 3'd0, 48'h0},
         '{8'h29, 3'd0, 48'h0},
         '{8'h2A, 3'd0, 48'h0},
         '{8'h20, 3'd3, {"%20", 24'd0}},        // space is escaped, not '+'
         '{8'h7E, 3'd3, {"%7e", 24'd0}},        // tilde is escaped
         '{8'h27, 3'd0, 48'h0},                 // apostrophe is escaped
         '{8'h01, 3'd0, 48'h0},
         '{8'h7F, 3'd0, 48'h0},
         '{8'h80, 3'd6, "%c2%80"},
         '{8'hBF, 3'd0, 48'h0},
         '{8'hC0, 3'd6, "%c3%80"},
         '{8'hFF, 3'd0, 48'h0}
      };
   end

   // ---------------------------------------------------------------- result checker

   always @(posedge clock) begin : check_chars
      enc_char_type want;
      if (!reset && rsp_strobe) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected beat: rsp_out_char=%h rsp_last_of_run=%b",
                   rsp_out_char, rsp_last_of_run);
            mismatches++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_out_char !== want.ch) begin
               $error("rsp_out_char: expected %h, got %h", want.ch, rsp_out_char);
               mismatches++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("rsp_last_of_run: expected %b, got %b", want.last, rsp_last_of_run);
               mismatches++;
            end
         end
      end
   end

   // Hang detector: any accepted input or strobed result counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HangLimit) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_in_byte  = 8'h00;
      mismatches   = 0;
      quiet_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      for (int i = 0; i < NumDirected; i++) begin
         if (i > 0) maybe_idle();
         drive_beat(directed_rows[i].in_byte);
         if (directed_rows[i].n_typed == 0) begin
            predict_encoding(directed_rows[i].in_byte);
         end else begin
            for (int k = 0; k < directed_rows[i].n_typed; k++) begin
               pending_chars.push_back('{
                  ch:   directed_rows[i].typed[47 - 8*k -: 8],
                  last: (k == directed_rows[i].n_typed - 1)});
            end
         end
      end

      // Random bytes; the tail goes back to back to keep the queue full and busy asserted
      for (int i = 0; i < RandomBeats; i++) begin
         logic [7:0] b;
         b = pick_byte();
         if (i < RandomBeats - SteadyBeats) maybe_idle();
         drive_beat(b);
         predict_encoding(b);
      end
      start <= 1'b0;

      // Drain; the hang detector covers a block that never finishes
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0 && pending_chars.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
